@@ hw/rtl/gce_pkg.sv @@
// Shared types, field widths, register indexes and helpers for the glyph color expander.
// Used by gce_addr_unit, gce_seq and glyph_color_expand_scaled; depends on nothing else.
package gce_pkg;

  // Field widths of the input word, the result word and the registers.
  localparam int unsigned ROW_W      = 16;
  localparam int unsigned ROW_IDX_W  = 4;
  localparam int unsigned WIDTH_W    = 5;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned ROWIDX_W   = 5;
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned STRIDE_W   = 16;
  localparam int unsigned BPP_W      = 3;
  localparam int unsigned SCALE_W    = 2;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // Packed stream words, padded to whole bytes.
  localparam int unsigned S_FIELDS_W = ROW_W + WIDTH_W + 2 * POS_W + ROWIDX_W + 2 * PIX_W;
  localparam int unsigned S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned M_DATA_W   = ADDR_W + PIX_W;

  // Bit offsets of the input fields inside the input word.
  localparam int unsigned OFS_ROW   = 0;
  localparam int unsigned OFS_WIDTH = OFS_ROW + ROW_W;
  localparam int unsigned OFS_COL   = OFS_WIDTH + WIDTH_W;
  localparam int unsigned OFS_LINE  = OFS_COL + POS_W;
  localparam int unsigned OFS_RIDX  = OFS_LINE + POS_W;
  localparam int unsigned OFS_FG    = OFS_RIDX + ROWIDX_W;
  localparam int unsigned OFS_BG    = OFS_FG + PIX_W;

  // Parameter defaults.
  localparam int unsigned DEF_MAX_FONT_WIDTH = 16;
  localparam int unsigned DEF_MAX_SCALE      = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BPP         = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X     = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y     = 8'd4;

  // Register reset values.
  localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd4;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 2'd1;

  // Operations of the shared address unit.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_MUL,
    OP_BASE,
    OP_XOFF,
    OP_STEP
  } gce_op_e;

  // Byte-lane mask for a pixel of bpp bytes (bpp already in 1..4).
  function automatic logic [PIX_W-1:0] pixel_mask(input logic [BPP_W-1:0] bpp);
    logic [PIX_W-1:0] m;
    unique case (bpp)
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

@@ hw/rtl/gce_addr_unit.sv @@
// Shared address datapath: one registered multiply step and a single 32-bit adder.
// Depends on gce_pkg; driven by the operation code from gce_seq.
module gce_addr_unit #(
  parameter int unsigned YW = 14,
  parameter int unsigned XW = 13
) (
  input  logic                            clk_i,
  input  gce_pkg::gce_op_e                op_i,
  input  logic [YW-1:0]                   y_i,
  input  logic [XW-1:0]                   colsx_i,
  input  logic [gce_pkg::ADDR_W-1:0]      frame_base_i,
  input  logic [gce_pkg::STRIDE_W-1:0]    stride_i,
  input  logic [gce_pkg::BPP_W-1:0]       bpp_i,
  output logic [gce_pkg::ADDR_W-1:0]      addr_o
);

  localparam int unsigned PW = YW + gce_pkg::STRIDE_W;
  localparam int unsigned OW = XW + gce_pkg::BPP_W;

  logic [PW-1:0]               prod_q;
  logic [OW-1:0]               xoff_q;
  logic [gce_pkg::ADDR_W-1:0]  addr_q, addr_d;
  logic [gce_pkg::ADDR_W-1:0]  add_a, add_b, add_sum;

  // Operand selection for the one shared adder.
  always_comb begin
    add_a = addr_q;
    add_b = '0;
    case (op_i)
      gce_pkg::OP_BASE: begin
        add_a = frame_base_i;
        add_b = gce_pkg::ADDR_W'(prod_q);
      end
      gce_pkg::OP_XOFF: add_b = gce_pkg::ADDR_W'(xoff_q);
      gce_pkg::OP_STEP: add_b = gce_pkg::ADDR_W'(bpp_i);
      default:          add_b = '0;
    endcase
  end

  assign add_sum = add_a + add_b;

  // The address register only moves on adder operations.
  always_comb begin
    case (op_i)
      gce_pkg::OP_BASE,
      gce_pkg::OP_XOFF,
      gce_pkg::OP_STEP: addr_d = add_sum;
      default:          addr_d = addr_q;
    endcase
  end

  // Line offset and column offset products, then the running address.
  always_ff @(posedge clk_i) begin
    if (op_i == gce_pkg::OP_MUL) begin
      prod_q <= PW'(y_i * stride_i);
      xoff_q <= OW'(colsx_i * bpp_i);
    end
    addr_q <= addr_d;
  end

  assign addr_o = addr_q;

endmodule

@@ hw/rtl/gce_seq.sv @@
// Row sequencer: takes one input word, walks lines, dots and repeats, drives the result word.
// Depends on gce_pkg; steers gce_addr_unit through an operation code.
module gce_seq #(
  parameter int unsigned MAX_FONT_WIDTH = gce_pkg::DEF_MAX_FONT_WIDTH,
  parameter int unsigned MAX_SCALE      = gce_pkg::DEF_MAX_SCALE,
  parameter int unsigned YW             = 14,
  parameter int unsigned XW             = 13
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gce_pkg::S_DATA_W-1:0]  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_last_o,
  output logic [gce_pkg::PIX_W-1:0]     out_pixel_o,
  input  logic [gce_pkg::SCALE_W-1:0]   sx_i,
  input  logic [gce_pkg::SCALE_W-1:0]   sy_i,
  input  logic [gce_pkg::BPP_W-1:0]     bpp_i,
  output gce_pkg::gce_op_e              op_o,
  output logic [YW-1:0]                 y_o,
  output logic [XW-1:0]                 colsx_o
);

  localparam int unsigned DW = (MAX_FONT_WIDTH > 1) ? $clog2(MAX_FONT_WIDTH) : 1;
  localparam int unsigned RW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam logic [gce_pkg::WIDTH_W-1:0] WidthMax = gce_pkg::WIDTH_W'(MAX_FONT_WIDTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_BASE = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_q, state_d;
  logic       base_done_q, base_done_d;

  logic [DW-1:0] dot_q, dot_d;
  logic [RW-1:0] rx_q, rx_d;
  logic [RW-1:0] ry_q, ry_d;

  logic [gce_pkg::ROW_W-1:0]   bits_q;
  logic [gce_pkg::WIDTH_W-1:0] wid_q;
  logic [YW-1:0]               ysc_q;
  logic [XW-1:0]               colsx_q;
  logic [gce_pkg::PIX_W-1:0]   fg_q, bg_q;

  logic [gce_pkg::ROW_W-1:0]    in_bits;
  logic [gce_pkg::WIDTH_W-1:0]  in_width, eff_width;
  logic [gce_pkg::POS_W-1:0]    in_col, in_line;
  logic [gce_pkg::ROWIDX_W-1:0] in_ridx;
  logic [gce_pkg::POS_W:0]      in_ybase;

  logic in_fire, out_fire;
  logic dot_end, rx_end, ry_end;
  logic [gce_pkg::ROW_IDX_W-1:0] bit_idx;

  // Field unpacking.
  assign in_bits  = in_data_i[gce_pkg::OFS_ROW   +: gce_pkg::ROW_W];
  assign in_width = in_data_i[gce_pkg::OFS_WIDTH +: gce_pkg::WIDTH_W];
  assign in_col   = in_data_i[gce_pkg::OFS_COL   +: gce_pkg::POS_W];
  assign in_line  = in_data_i[gce_pkg::OFS_LINE  +: gce_pkg::POS_W];
  assign in_ridx  = in_data_i[gce_pkg::OFS_RIDX  +: gce_pkg::ROWIDX_W];
  assign in_ybase = (gce_pkg::POS_W + 1)'(in_line) + (gce_pkg::POS_W + 1)'(in_ridx);

  // Wide glyphs are cut to the font width limit.
  assign eff_width = (in_width > WidthMax) ? WidthMax : in_width;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_EMIT);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  // End-of-walk flags for the three nested counters.
  assign rx_end  = (gce_pkg::SCALE_W'(rx_q) == sx_i - 2'd1);
  assign ry_end  = (gce_pkg::SCALE_W'(ry_q) == sy_i - 2'd1);
  assign dot_end = (gce_pkg::WIDTH_W'(dot_q) == wid_q - 5'd1);

  // Dot x sits at bit ROW_W-1-x of the font row.
  assign bit_idx     = gce_pkg::ROW_IDX_W'(gce_pkg::ROW_W - 1) - gce_pkg::ROW_IDX_W'(dot_q);
  assign out_pixel_o = (bits_q[bit_idx] ? fg_q : bg_q) & gce_pkg::pixel_mask(bpp_i);
  assign out_last_o  = dot_end && rx_end && ry_end;

  assign y_o     = ysc_q + YW'(ry_q);
  assign colsx_o = colsx_q;

  // Sequencer: multiply, base add, column add, then one pixel per accepted result.
  always_comb begin
    state_d     = state_q;
    base_done_d = base_done_q;
    dot_d       = dot_q;
    rx_d        = rx_q;
    ry_d        = ry_q;
    op_o        = gce_pkg::OP_HOLD;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && (eff_width != '0)) begin
          state_d = S_MUL;
          dot_d   = '0;
          rx_d    = '0;
          ry_d    = '0;
        end
      end
      S_MUL: begin
        op_o        = gce_pkg::OP_MUL;
        state_d     = S_BASE;
        base_done_d = 1'b0;
      end
      S_BASE: begin
        if (!base_done_q) begin
          op_o        = gce_pkg::OP_BASE;
          base_done_d = 1'b1;
        end else begin
          op_o    = gce_pkg::OP_XOFF;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_fire) begin
          if (!rx_end) begin
            op_o = gce_pkg::OP_STEP;
            rx_d = rx_q + 1'b1;
          end else if (!dot_end) begin
            op_o  = gce_pkg::OP_STEP;
            rx_d  = '0;
            dot_d = dot_q + 1'b1;
          end else if (!ry_end) begin
            rx_d    = '0;
            dot_d   = '0;
            ry_d    = ry_q + 1'b1;
            state_d = S_MUL;
          end else begin
            rx_d    = '0;
            dot_d   = '0;
            ry_d    = '0;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_done_q <= 1'b0;
      dot_q       <= '0;
      rx_q        <= '0;
      ry_q        <= '0;
    end else begin
      state_q     <= state_d;
      base_done_q <= base_done_d;
      dot_q       <= dot_d;
      rx_q        <= rx_d;
      ry_q        <= ry_d;
    end
  end

  // Item registers, loaded when a word is taken.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      bits_q  <= in_bits;
      wid_q   <= eff_width;
      ysc_q   <= YW'(in_ybase * sy_i);
      colsx_q <= XW'(in_col * sx_i);
      fg_q    <= in_data_i[gce_pkg::OFS_FG +: gce_pkg::PIX_W];
      bg_q    <= in_data_i[gce_pkg::OFS_BG +: gce_pkg::PIX_W];
    end
  end

`ifndef NO_ASSERTIONS
  a_dot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (gce_pkg::WIDTH_W'(dot_q) < wid_q))
    else $error("dot counter ran past the glyph width");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_last_o) |=> (state_q == S_IDLE))
    else $error("sequencer kept running after the last word");

  a_zero_width_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_width == '0)) |=> (state_q == S_IDLE))
    else $error("zero-width row started a walk");

  a_mul_then_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |=> (state_q == S_BASE && !base_done_q))
    else $error("line setup skipped the base add");
`endif

endmodule

@@ hw/rtl/glyph_color_expand_scaled.sv @@
// Top level of the glyph color expander: configuration registers, sequencer and address unit.
// Depends on gce_pkg, gce_seq and gce_addr_unit.
//
// Expands one 1-bit font row per input word into framebuffer pixel writes, each dot repeated
// scale_x times across and the row scale_y times down; the final write of a row carries tlast.
// One word is taken at a time. After a word is taken, each scan line starts with one multiply
// step and two adds to set up the line address, then gives one write per cycle while the
// output is ready. The single 32-bit address adder serves both line setup and the per-pixel
// step. A row of width zero is taken and gives no writes. Configuration is taken in any cycle
// and must only be written while no row is in progress.
module glyph_color_expand_scaled #(
  parameter int unsigned MAX_FONT_WIDTH = gce_pkg::DEF_MAX_FONT_WIDTH,
  parameter int unsigned MAX_SCALE      = gce_pkg::DEF_MAX_SCALE
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input words.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // row_bits[15:0], glyph_width[20:16], glyph_col[32:21], glyph_line[44:33],
  // row_index[49:45], fg_pixel[81:50], bg_pixel[113:82], zero pad[119:114]
  input  logic [gce_pkg::S_DATA_W-1:0]    s_axis_tdata,
  // Result words.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // write_addr[31:0], write_pixel[63:32]
  output logic [gce_pkg::M_DATA_W-1:0]    m_axis_tdata,
  output logic                            m_axis_tlast,
  // Configuration writes.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gce_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gce_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned YMax = ((2 ** gce_pkg::POS_W - 1) + (2 ** gce_pkg::ROWIDX_W - 1))
                                 * MAX_SCALE + MAX_SCALE - 1;
  localparam int unsigned YW   = $clog2(YMax + 1);
  localparam int unsigned XW   = $clog2((2 ** gce_pkg::POS_W - 1) * MAX_SCALE + 1);
  localparam logic [gce_pkg::SCALE_W-1:0] ScaleMax = gce_pkg::SCALE_W'(MAX_SCALE);

  logic [gce_pkg::ADDR_W-1:0]   frame_base_q;
  logic [gce_pkg::STRIDE_W-1:0] line_stride_q;
  logic [gce_pkg::BPP_W-1:0]    bpp_q;
  logic [gce_pkg::SCALE_W-1:0]  scale_x_q, scale_y_q;

  logic [gce_pkg::BPP_W-1:0]    bpp_eff;
  logic [gce_pkg::SCALE_W-1:0]  sx_eff, sy_eff;

  gce_pkg::gce_op_e             op;
  logic [YW-1:0]                y_val;
  logic [XW-1:0]                colsx;
  logic [gce_pkg::ADDR_W-1:0]   write_addr;
  logic [gce_pkg::PIX_W-1:0]    write_pixel;

  assign cfg_ready_o = 1'b1;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q  <= '0;
      line_stride_q <= '0;
      bpp_q         <= gce_pkg::BPP_RESET;
      scale_x_q     <= gce_pkg::SCALE_RESET;
      scale_y_q     <= gce_pkg::SCALE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        gce_pkg::REG_FRAME_BASE:  frame_base_q  <= cfg_data_i;
        gce_pkg::REG_LINE_STRIDE: line_stride_q <= cfg_data_i[gce_pkg::STRIDE_W-1:0];
        gce_pkg::REG_BPP:         bpp_q         <= cfg_data_i[gce_pkg::BPP_W-1:0];
        gce_pkg::REG_SCALE_X:     scale_x_q     <= cfg_data_i[gce_pkg::SCALE_W-1:0];
        gce_pkg::REG_SCALE_Y:     scale_y_q     <= cfg_data_i[gce_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range settings fold into the nearest legal value.
  always_comb begin
    if (bpp_q == '0) begin
      bpp_eff = 3'd1;
    end else if (bpp_q > 3'd4) begin
      bpp_eff = 3'd4;
    end else begin
      bpp_eff = bpp_q;
    end
    if (scale_x_q == '0) begin
      sx_eff = 2'd1;
    end else if (scale_x_q > ScaleMax) begin
      sx_eff = ScaleMax;
    end else begin
      sx_eff = scale_x_q;
    end
    if (scale_y_q == '0) begin
      sy_eff = 2'd1;
    end else if (scale_y_q > ScaleMax) begin
      sy_eff = ScaleMax;
    end else begin
      sy_eff = scale_y_q;
    end
  end

  gce_seq #(
    .MAX_FONT_WIDTH(MAX_FONT_WIDTH),
    .MAX_SCALE     (MAX_SCALE),
    .YW            (YW),
    .XW            (XW)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_last_o (m_axis_tlast),
    .out_pixel_o(write_pixel),
    .sx_i       (sx_eff),
    .sy_i       (sy_eff),
    .bpp_i      (bpp_eff),
    .op_o       (op),
    .y_o        (y_val),
    .colsx_o    (colsx)
  );

  gce_addr_unit #(
    .YW(YW),
    .XW(XW)
  ) u_addr (
    .clk_i       (clk_i),
    .op_i        (op),
    .y_i         (y_val),
    .colsx_i     (colsx),
    .frame_base_i(frame_base_q),
    .stride_i    (line_stride_q),
    .bpp_i       (bpp_eff),
    .addr_o      (write_addr)
  );

  assign m_axis_tdata = {write_pixel, write_addr};

endmodule
